// ===== design/rgb_hsb_color_converter_assert.svh =====
// Assertion macros used by the checker of the colour converter.
`ifndef RGB_HSB_COLOR_CONVERTER_ASSERT_SVH
`define RGB_HSB_COLOR_CONVERTER_ASSERT_SVH

// Same-cycle implication.
`define RHC_ASSERT_IMPLY(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rhc_pkg.sv =====
package rhc_pkg;

  localparam logic CMD_RGB2HSB = 1'b0;
  localparam logic CMD_HSB2RGB = 1'b1;

  localparam logic [8:0]  HUE_WRAP   = 9'd360;
  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [5:0]  SECTOR_DEG = 6'd60;
  localparam logic [12:0] HUE_SCALE  = 13'd6000;

  // Divider geometry: one quotient bit per stage.
  localparam int DIV_STEPS = 9;
  localparam int REM_W     = 17;
  localparam int DVS_W     = 8;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] bri;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem_sat;
    logic [DVS_W-1:0]     dvs_sat;
    logic [DIV_STEPS-1:0] q_sat;
    logic [REM_W-1:0]     rem_hue;
    logic [DVS_W-1:0]     dvs_hue;
    logic [DIV_STEPS-1:0] q_hue;
    side_t                side;
  } div_t;

endpackage

// ===== design/rhc_if.sv =====
interface rhc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [8:0] hue_in;
  logic [6:0] sat_in;
  logic [6:0] bri_in;

  modport source (output valid, cmd, red_in, green_in, blue_in, hue_in, sat_in, bri_in,
                  input ready);
  modport sink (input valid, cmd, red_in, green_in, blue_in, hue_in, sat_in, bri_in,
                output ready);
endinterface

interface rhc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [8:0] hue_out;
  logic [6:0] sat_out;
  logic [6:0] bri_out;

  modport source (output valid, red_out, green_out, blue_out, hue_out, sat_out, bri_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, hue_out, sat_out, bri_out,
                output ready);
endinterface

// ===== design/rhc_divider.sv =====
module rhc_divider (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rhc_pkg::div_t din,
  output logic         out_valid,
  input  logic         out_ready,
  output rhc_pkg::div_t dout
);
  import rhc_pkg::*;

  // One restoring step on both the saturation and the hue division.
  function automatic div_t div_step(input div_t x, input logic [3:0] sh);
    logic [REM_W-1:0] ts;
    logic [REM_W-1:0] th;
    div_t             y;
    ts = REM_W'(x.dvs_sat) << sh;
    th = REM_W'(x.dvs_hue) << sh;
    y  = x;
    if (x.rem_sat >= ts) begin
      y.rem_sat    = x.rem_sat - ts;
      y.q_sat[sh]  = 1'b1;
    end
    if (x.rem_hue >= th) begin
      y.rem_hue    = x.rem_hue - th;
      y.q_hue[sh]  = 1'b1;
    end
    return y;
  endfunction

  logic [DIV_STEPS-1:0] vld;
  logic [DIV_STEPS:0]   rdy;
  div_t                 stg [DIV_STEPS];

  assign rdy[DIV_STEPS] = out_ready;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    assign rdy[s] = !vld[s] || rdy[s+1];

    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld[s] <= in_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          stg[s] <= div_step(din, 4'(DIV_STEPS - 1 - s));
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld[s] <= vld[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          stg[s] <= div_step(stg[s-1], 4'(DIV_STEPS - 1 - s));
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[DIV_STEPS-1];
  assign dout      = stg[DIV_STEPS-1];

endmodule

// ===== design/rgb_hsb_color_converter.sv =====
// Pipeline: 14 register stages, A to D, nine divider stages and the output register.
// Throughput: one word per clock while the output is not stalled, set by the fully pipelined
// datapath with a restoring divider of nine stages, one quotient bit per stage.
// Each stage advances independently, so bubbles close up while the output is stalled.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module rgb_hsb_color_converter (
  input logic       clk,
  input logic       rst,
  rhc_in_if.sink    rx,
  rhc_out_if.source tx
);
  import rhc_pkg::*;

  typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_sel_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] mx;
    logic [7:0] delta;
    max_sel_t   sel;
    logic [6:0] sat;
    logic [6:0] bri;
    logic [14:0] vprod;
    logic [2:0] n;
    logic [5:0] rem;
  } a_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  mx;
    logic [7:0]  delta;
    logic [16:0] num;
    logic [14:0] sat_num;
    logic [6:0]  bri;
    logic [7:0]  v;
    logic [6:0]  sat;
    logic [2:0]  n;
    logic [12:0] srem;
    logic [12:0] scom;
  } b_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  mx;
    logic [7:0]  delta;
    logic [16:0] num;
    logic [14:0] sat_num;
    logic [6:0]  bri;
    logic [7:0]  v;
    logic        sat_zero;
    logic [2:0]  n;
    logic [14:0] a_num;
    logic [20:0] b_num;
    logic [20:0] c_num;
  } c_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] bri;
  } f_t;

  // floor(mx*100/255) using x/255 = (x+1)*257 >> 16, exact below 65535.
  function automatic logic [6:0] bri_of_max(input logic [7:0] mx);
    logic [23:0] t;
    logic [23:0] p;
    t = 24'(15'(mx) * 15'd100) + 24'd1;
    p = {t[15:0], 8'd0} + t;
    return p[22:16];
  endfunction

  // floor(y/100) for y up to 25500: drop two bits, then multiply by 2^18/25.
  function automatic logic [7:0] div100(input logic [14:0] y);
    logic [26:0] p;
    p = 27'(y[14:2]) * 27'd10486;
    return p[25:18];
  endfunction

  // floor(y/6000) for y up to 1530000: drop four bits, then multiply by 2^26/375.
  function automatic logic [7:0] div6000(input logic [20:0] y);
    logic [34:0] p;
    p = 35'(y[20:4]) * 35'd178957;
    return p[33:26];
  endfunction

  logic va, vb, vc, vd, vf;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_f;
  a_t   pa, a_next;
  b_t   pb, b_next;
  c_t   pc, c_next;
  div_t pd, d_next;
  f_t   pf, f_next;
  logic div_in_ready;
  logic div_out_valid;
  div_t div_out;

  assign rdy_f = !vf || tx.ready;
  assign rdy_d = !vd || div_in_ready;
  assign rdy_c = !vc || rdy_d;
  assign rdy_b = !vb || rdy_c;
  assign rdy_a = !va || rdy_b;
  assign rx.ready = rdy_a;

  // Stage A: max/min and delta, input clamping, hue sector.
  always_comb begin
    logic [7:0] mx;
    logic [7:0] mn;
    logic [8:0] h;
    logic [8:0] base;
    logic [6:0] sat_c;
    logic [6:0] bri_c;
    mx = rx.red_in;
    mn = rx.red_in;
    if (rx.green_in > mx) mx = rx.green_in;
    if (rx.blue_in > mx) mx = rx.blue_in;
    if (rx.green_in < mn) mn = rx.green_in;
    if (rx.blue_in < mn) mn = rx.blue_in;

    a_next.cmd   = rx.cmd;
    a_next.red   = rx.red_in;
    a_next.green = rx.green_in;
    a_next.blue  = rx.blue_in;
    a_next.mx    = mx;
    a_next.delta = mx - mn;
    if (rx.red_in == mx) begin
      a_next.sel = MAX_RED;
    end else if (rx.green_in == mx) begin
      a_next.sel = MAX_GREEN;
    end else begin
      a_next.sel = MAX_BLUE;
    end

    // A full turn and anything beyond it wrap to zero.
    h     = (rx.hue_in >= HUE_WRAP) ? 9'd0 : rx.hue_in;
    sat_c = (rx.sat_in > PCT_MAX) ? PCT_MAX : rx.sat_in;
    bri_c = (rx.bri_in > PCT_MAX) ? PCT_MAX : rx.bri_in;
    a_next.sat   = sat_c;
    a_next.bri   = bri_c;
    a_next.vprod = 15'(bri_c) * 15'd255;

    if (h >= 9'd300) begin
      a_next.n = 3'd5;
      base     = 9'd300;
    end else if (h >= 9'd240) begin
      a_next.n = 3'd4;
      base     = 9'd240;
    end else if (h >= 9'd180) begin
      a_next.n = 3'd3;
      base     = 9'd180;
    end else if (h >= 9'd120) begin
      a_next.n = 3'd2;
      base     = 9'd120;
    end else if (h >= 9'(SECTOR_DEG)) begin
      a_next.n = 3'd1;
      base     = 9'(SECTOR_DEG);
    end else begin
      a_next.n = 3'd0;
      base     = 9'd0;
    end
    a_next.rem = 6'(h - base);
  end

  // Stage B: hue numerator, brightness, value and the saturation products.
  always_comb begin
    logic signed [18:0] sr, sg, sb, sd, num;
    sr = 19'(pa.red);
    sg = 19'(pa.green);
    sb = 19'(pa.blue);
    sd = 19'(pa.delta);
    case (pa.sel)
      MAX_RED:   num = 19'sd60 * (sg - sb);
      MAX_GREEN: num = 19'sd120 * sd + 19'sd60 * (sb - sr);
      MAX_BLUE:  num = 19'sd240 * sd + 19'sd60 * (sr - sg);
      default:   num = 19'sd0;
    endcase
    if (num < 0) begin
      num = num + 19'sd360 * sd;
    end

    b_next.cmd     = pa.cmd;
    b_next.mx      = pa.mx;
    b_next.delta   = pa.delta;
    b_next.num     = num[16:0];
    b_next.sat_num = 15'(pa.delta) * 15'd100;
    b_next.bri     = bri_of_max(pa.mx);
    b_next.v       = div100(pa.vprod);
    b_next.sat     = pa.sat;
    b_next.n       = pa.n;
    b_next.srem    = 13'(pa.sat) * 13'(pa.rem);
    b_next.scom    = 13'(pa.sat) * 13'(SECTOR_DEG - pa.rem);
  end

  // Stage C: numerators of a, b and c.
  always_comb begin
    c_next.cmd      = pb.cmd;
    c_next.mx       = pb.mx;
    c_next.delta    = pb.delta;
    c_next.num      = pb.num;
    c_next.sat_num  = pb.sat_num;
    c_next.bri      = pb.bri;
    c_next.v        = pb.v;
    c_next.sat_zero = (pb.sat == 7'd0);
    c_next.n        = pb.n;
    c_next.a_num    = 15'(pb.v) * 15'(PCT_MAX - pb.sat);
    c_next.b_num    = 21'(pb.v) * 21'(HUE_SCALE - pb.srem);
    c_next.c_num    = 21'(pb.v) * 21'(HUE_SCALE - pb.scom);
  end

  // Stage D: finish HSB to RGB, and load the divider for RGB to HSB.
  always_comb begin
    logic [7:0] a, b, c, rr, gg, bb;
    a = div100(pc.a_num);
    b = div6000(pc.b_num);
    c = div6000(pc.c_num);
    if (pc.sat_zero) begin
      rr = pc.v; gg = pc.v; bb = pc.v;
    end else begin
      case (pc.n)
        3'd0:    begin rr = pc.v; gg = c;    bb = a;    end
        3'd1:    begin rr = b;    gg = pc.v; bb = a;    end
        3'd2:    begin rr = a;    gg = pc.v; bb = c;    end
        3'd3:    begin rr = a;    gg = b;    bb = pc.v; end
        3'd4:    begin rr = c;    gg = a;    bb = pc.v; end
        default: begin rr = pc.v; gg = a;    bb = b;    end
      endcase
    end

    d_next.rem_sat = REM_W'(pc.sat_num);
    d_next.dvs_sat = pc.mx;
    d_next.q_sat   = '0;
    d_next.rem_hue = pc.num;
    d_next.dvs_hue = pc.delta;
    d_next.q_hue   = '0;
    d_next.side.cmd = pc.cmd;
    d_next.side.bri = pc.bri;
    if (pc.cmd == CMD_HSB2RGB) begin
      d_next.side.red   = rr;
      d_next.side.green = gg;
      d_next.side.blue  = bb;
    end else begin
      d_next.side.red   = 8'd0;
      d_next.side.green = 8'd0;
      d_next.side.blue  = 8'd0;
    end
  end

  rhc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vd),
    .in_ready  (div_in_ready),
    .din       (pd),
    .out_valid (div_out_valid),
    .out_ready (rdy_f),
    .dout      (div_out)
  );

  // Output stage: a black or grey colour has neither saturation nor hue.
  always_comb begin
    logic [6:0] sat;
    f_next.red   = div_out.side.red;
    f_next.green = div_out.side.green;
    f_next.blue  = div_out.side.blue;
    if (div_out.side.cmd == CMD_RGB2HSB) begin
      sat = (div_out.side.bri == 7'd0) ? 7'd0 : div_out.q_sat[6:0];
      f_next.bri = div_out.side.bri;
      f_next.sat = sat;
      f_next.hue = (sat == 7'd0) ? 9'd0 : div_out.q_hue;
    end else begin
      sat        = 7'd0;
      f_next.bri = 7'd0;
      f_next.sat = sat;
      f_next.hue = 9'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      vf <= 1'b0;
    end else begin
      if (rdy_a) va <= rx.valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
      if (rdy_f) vf <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) pa <= a_next;
    if (rdy_b) pb <= b_next;
    if (rdy_c) pc <= c_next;
    if (rdy_d) pd <= d_next;
    if (rdy_f) pf <= f_next;
  end

  assign tx.valid     = vf;
  assign tx.red_out   = pf.red;
  assign tx.green_out = pf.green;
  assign tx.blue_out  = pf.blue;
  assign tx.hue_out   = pf.hue;
  assign tx.sat_out   = pf.sat;
  assign tx.bri_out   = pf.bri;

endmodule

// ===== design/rhc_checker.sv =====
`include "rgb_hsb_color_converter_assert.svh"

module rhc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [8:0] hue_out,
  input logic [6:0] sat_out,
  input logic [6:0] bri_out
);

  // A reset empties the pipeline, so nothing is offered on the next cycle.
  `RHC_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid, "word offered straight after reset")

  `RHC_ASSERT_NEXT(a_stall_hold, clk, out_valid && !out_ready && !rst, out_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(hue_out) && $stable(sat_out) && $stable(bri_out), "stalled word changed")

  // Only one direction's fields may carry a value.
  `RHC_ASSERT_IMPLY(a_one_side, clk, out_valid && (hue_out != 9'd0 || sat_out != 7'd0 || bri_out != 7'd0), red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0, "both RGB and HSB fields set")

  `RHC_ASSERT_IMPLY(a_hsb_range, clk, out_valid, bri_out <= 7'd100 && sat_out <= 7'd100 && hue_out <= 9'd359, "HSB field out of range")

  // Hue needs saturation and saturation needs brightness.
  `RHC_ASSERT_IMPLY(a_hsb_chain, clk, out_valid, (sat_out == 7'd0 || bri_out != 7'd0) && (hue_out == 9'd0 || sat_out != 7'd0), "hue or saturation without its base")

endmodule

bind rgb_hsb_color_converter rhc_checker u_rhc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tx.valid),
  .out_ready (tx.ready),
  .red_out   (tx.red_out),
  .green_out (tx.green_out),
  .blue_out  (tx.blue_out),
  .hue_out   (tx.hue_out),
  .sat_out   (tx.sat_out),
  .bri_out   (tx.bri_out)
);

// ===== test/rgb_hsb_color_converter_tb.sv =====
module rgb_hsb_color_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam int RANDOM_WORDS = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] bri;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] bri;
  } colour_t;

  class colour_scoreboard;
    colour_t     expected_colours[$];
    int unsigned mismatches;
    int unsigned rgb_words;
    int unsigned hsb_words;
    int unsigned colours_checked;

    function new();
      mismatches      = 0;
      rgb_words       = 0;
      hsb_words       = 0;
      colours_checked = 0;
    endfunction

    function colour_t convert(pixel_t p);
      colour_t     res;
      int unsigned mx, mn, delta, hue_c, sat_c, bri_c;
      int unsigned h, s, v, sector, rem, a, b, c;
      int          num;
      res = '0;
      if (p.cmd == CMD_RGB2HSB) begin
        mx = p.red;
        mn = p.red;
        if (p.green > mx) mx = p.green;
        if (p.blue > mx) mx = p.blue;
        if (p.green < mn) mn = p.green;
        if (p.blue < mn) mn = p.blue;
        delta = mx - mn;
        bri_c = mx * PCT_MAX / 255;
        sat_c = (bri_c > 0) ? delta * PCT_MAX / mx : 0;
        hue_c = 0;
        // A non-zero saturation implies a non-zero spread, so the division is safe.
        if (sat_c != 0) begin
          if (p.red == mx)
            num = 60 * (int'(p.green) - int'(p.blue));
          else if (p.green == mx)
            num = 120 * int'(delta) + 60 * (int'(p.blue) - int'(p.red));
          else
            num = 240 * int'(delta) + 60 * (int'(p.red) - int'(p.green));
          if (num < 0) num += int'(HUE_WRAP) * int'(delta);
          hue_c = num / int'(delta);
          if (hue_c > 359) hue_c = 359;
        end
        res.hue = hue_c[8:0];
        res.sat = sat_c[6:0];
        res.bri = bri_c[6:0];
      end else begin
        h = (p.hue > HUE_WRAP) ? HUE_WRAP : p.hue;
        s = (p.sat > PCT_MAX) ? PCT_MAX : p.sat;
        v = (p.bri > PCT_MAX) ? PCT_MAX : p.bri;
        v = v * 255 / PCT_MAX;
        if (h == HUE_WRAP) h = 0;
        if (s == 0) begin
          res.red   = v[7:0];
          res.green = v[7:0];
          res.blue  = v[7:0];
        end else begin
          sector = h / 60;
          rem    = h % 60;
          a = v * (PCT_MAX - s) / PCT_MAX;
          b = v * (6000 - s * rem) / 6000;
          c = v * (6000 - s * (60 - rem)) / 6000;
          case (sector)
            0:       {res.red, res.green, res.blue} = {v[7:0], c[7:0], a[7:0]};
            1:       {res.red, res.green, res.blue} = {b[7:0], v[7:0], a[7:0]};
            2:       {res.red, res.green, res.blue} = {a[7:0], v[7:0], c[7:0]};
            3:       {res.red, res.green, res.blue} = {a[7:0], b[7:0], v[7:0]};
            4:       {res.red, res.green, res.blue} = {c[7:0], a[7:0], v[7:0]};
            default: {res.red, res.green, res.blue} = {v[7:0], a[7:0], b[7:0]};
          endcase
        end
      end
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      expected_colours.push_back(convert(p));
      if (p.cmd == CMD_RGB2HSB) rgb_words++;
      else hsb_words++;
    endfunction

    function void compare_field(string name, int unsigned exp_val, logic [8:0] act_val);
      if (act_val !== exp_val[8:0]) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      end
    endfunction

    function void check_colour(colour_t got);
      colour_t exp_c;
      if (expected_colours.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      exp_c = expected_colours.pop_front();
      colours_checked++;
      compare_field("red_out",   exp_c.red,   {1'b0, got.red});
      compare_field("green_out", exp_c.green, {1'b0, got.green});
      compare_field("blue_out",  exp_c.blue,  {1'b0, got.blue});
      compare_field("hue_out",   exp_c.hue,   got.hue);
      compare_field("sat_out",   exp_c.sat,   {2'b0, got.sat});
      compare_field("bri_out",   exp_c.bri,   {2'b0, got.bri});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   quiet_phase;
  int unsigned cycle_count;

  rhc_in_if  rx_bus ();
  rhc_out_if tx_bus ();

  colour_scoreboard sb = new();

  rgb_hsb_color_converter u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_bus),
    .tx  (tx_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back-to-back, with the occasional short or long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("rgb_hsb_color_converter regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rx_bus.valid && rx_bus.ready)
        sb.note_pixel({rx_bus.cmd, rx_bus.red_in, rx_bus.green_in, rx_bus.blue_in,
                       rx_bus.hue_in, rx_bus.sat_in, rx_bus.bri_in});
      if (tx_bus.valid && tx_bus.ready)
        sb.check_colour({tx_bus.red_out, tx_bus.green_out, tx_bus.blue_out,
                         tx_bus.hue_out, tx_bus.sat_out, tx_bus.bri_out});
    end
  end

  initial begin : sink_pacing
    int hold, gap;
    tx_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = $urandom_range(1, 24);
      tx_bus.ready <= 1'b1;
      repeat (hold) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        tx_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      rx_bus.valid <= 1'b0;
      @(negedge clk);
    end
    rx_bus.valid    <= 1'b1;
    rx_bus.cmd      <= p.cmd;
    rx_bus.red_in   <= p.red;
    rx_bus.green_in <= p.green;
    rx_bus.blue_in  <= p.blue;
    rx_bus.hue_in   <= p.hue;
    rx_bus.sat_in   <= p.sat;
    rx_bus.bri_in   <= p.bri;
    @(posedge clk);
    while (!rx_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_rgb(input int r, input int g, input int b);
    send_pixel({CMD_RGB2HSB, r[7:0], g[7:0], b[7:0], 9'd0, 7'd0, 7'd0});
  endtask

  task automatic send_hsb(input int h, input int s, input int v);
    send_pixel({CMD_HSB2RGB, 8'd0, 8'd0, 8'd0, h[8:0], s[6:0], v[6:0]});
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    int     kind, lvl;
    p.cmd   = 1'($urandom_range(0, 1));
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    p.hue   = 9'($urandom);
    p.sat   = 7'($urandom);
    p.bri   = 7'($urandom);
    kind = $urandom_range(0, 9);
    if (p.cmd == CMD_RGB2HSB) begin
      lvl = $urandom_range(0, 255);
      case (kind)
        0: {p.red, p.green, p.blue} = {lvl[7:0], lvl[7:0], lvl[7:0]};
        1: begin
          p.red   = 8'($urandom_range(0, 3));
          p.green = 8'($urandom_range(0, 3));
          p.blue  = 8'($urandom_range(0, 3));
        end
        2: {p.red, p.green} = {lvl[7:0], lvl[7:0]};
        3: {p.green, p.blue} = {lvl[7:0], lvl[7:0]};
        4: {p.red, p.blue} = {lvl[7:0], lvl[7:0]};
        default: ;
      endcase
    end else begin
      // Keep most words in range; the rest exercise the clamping.
      if (kind < 8) p.hue = 9'($urandom_range(0, 360));
      if (kind < 8) p.sat = 7'($urandom_range(0, 100));
      if (kind != 7) p.bri = 7'($urandom_range(0, 100));
      if (kind == 5) p.hue = 9'(60 * $urandom_range(0, 6));
      if (kind == 6) p.sat = 7'd0;
    end
    return p;
  endfunction

  initial begin
    rst             = 1'b1;
    quiet_phase     = 1'b0;
    cycle_count     = 0;
    rx_bus.valid    = 1'b0;
    rx_bus.cmd      = CMD_RGB2HSB;
    rx_bus.red_in   = '0;
    rx_bus.green_in = '0;
    rx_bus.blue_in  = '0;
    rx_bus.hue_in   = '0;
    rx_bus.sat_in   = '0;
    rx_bus.bri_in   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words: extremes, primaries, ties, near-black and the clamping cases.
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    send_rgb(2, 1, 0);
    send_rgb(3, 0, 0);
    send_rgb(255, 0, 1);
    send_rgb(128, 128, 128);
    send_hsb(0, 100, 100);
    send_hsb(360, 100, 100);
    send_hsb(511, 127, 127);
    send_hsb(359, 100, 100);
    send_hsb(60, 50, 75);
    send_hsb(120, 50, 75);
    send_hsb(180, 50, 75);
    send_hsb(240, 50, 75);
    send_hsb(300, 50, 75);
    send_hsb(200, 0, 50);
    send_hsb(90, 100, 0);
    send_hsb(30, 1, 1);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      send_pixel(random_pixel());
    end
    rx_bus.valid <= 1'b0;
    quiet_phase = 1'b0;

    while (sb.expected_colours.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d RGB words and %0d HSB words; %0d results checked.",
             sb.rgb_words, sb.hsb_words, sb.colours_checked);
    $display("Mismatches: %0d, results still outstanding: %0d.",
             sb.mismatches, sb.expected_colours.size());
    if (sb.mismatches == 0 && sb.expected_colours.size() == 0) begin
      $display("rgb_hsb_color_converter regression: pass");
    end else begin
      $display("rgb_hsb_color_converter regression: fail");
    end
    $finish;
  end

endmodule
